[design/srs_pkg.sv]
// ----------------------------------------------------------------------------
// Stable record sorter package
// Record types for both channels and the control word sent along the chain.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned TAG_OUT_BITS = 16;

  // One incoming record.
  typedef struct packed {
    logic signed [KEY_BITS-1:0]     sort_key;
    logic        [TAG_OUT_BITS-1:0] payload_tag;
    logic                           end_of_set;
  } in_item_t;

  // One record of the sorted output.
  typedef struct packed {
    logic signed [KEY_BITS-1:0]     sorted_key;
    logic        [TAG_OUT_BITS-1:0] sorted_tag;
    logic                           final_record;
    logic                           overflowed;
  } out_item_t;

  // Control word broadcast to every cell.
  typedef struct packed {
    logic insert;  // place the broadcast record into the chain
    logic shift;   // move every record one cell towards the head
  } cell_ctrl_t;

endpackage

[design/srs_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one item of a chosen type per transfer.
// ----------------------------------------------------------------------------
interface srs_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/srs_cell.sv]
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one record; takes the new record, its left neighbour's record or its
// right neighbour's record depending on the broadcast control.
// ----------------------------------------------------------------------------
module srs_cell #(
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srs_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [srs_pkg::KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0]             new_tag_i,
  input  logic                            left_valid_i,
  input  logic                            left_gt_i,
  input  logic signed [srs_pkg::KEY_BITS-1:0] left_key_i,
  input  logic [TAG_BITS-1:0]             left_tag_i,
  input  logic                            right_valid_i,
  input  logic signed [srs_pkg::KEY_BITS-1:0] right_key_i,
  input  logic [TAG_BITS-1:0]             right_tag_i,
  output logic                            valid_o,
  output logic                            gt_o,
  output logic signed [srs_pkg::KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0]             tag_o
);
  import srs_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0]        tag_q, tag_d;
  logic                       gt_self;

  // A held key strictly greater than the new one moves aside; equal keys stay
  // in front, which keeps arrival order.
  assign gt_self = valid_q && (key_q > new_key_i);

  // Next contents of the cell.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    priority if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      tag_d   = right_tag_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        valid_d = 1'b1;
        key_d   = left_key_i;
        tag_d   = left_tag_i;
      end else if ((gt_self || !valid_q) && left_valid_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        tag_d   = new_tag_i;
      end
    end
  end

  // Only the valid bit needs a reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign gt_o    = gt_self;
  assign key_o   = key_q;
  assign tag_o   = tag_q;

endmodule

[design/srs_chain.sv]
// ----------------------------------------------------------------------------
// Sorter chain
// A row of cells kept in ascending key order, read out at the head.
// ----------------------------------------------------------------------------
module srs_chain #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srs_pkg::cell_ctrl_t             ctrl_i,
  input  logic signed [srs_pkg::KEY_BITS-1:0] new_key_i,
  input  logic [TAG_BITS-1:0]             new_tag_i,
  output logic signed [srs_pkg::KEY_BITS-1:0] head_key_o,
  output logic [TAG_BITS-1:0]             head_tag_o,
  output logic                            second_valid_o,
  output logic                            full_o
);
  import srs_pkg::*;

  logic                       valid_w [MAX_RECORDS];
  logic                       gt_w    [MAX_RECORDS];
  logic signed [KEY_BITS-1:0] key_w   [MAX_RECORDS];
  logic [TAG_BITS-1:0]        tag_w   [MAX_RECORDS];

  // Each cell sees its two neighbours; the ends see a fixed boundary.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic                       lv, lg, rv;
    logic signed [KEY_BITS-1:0] lk, rk;
    logic [TAG_BITS-1:0]        lt, rt;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lk = new_key_i;
      assign lt = new_tag_i;
    end else begin : g_body
      assign lv = valid_w[i-1];
      assign lg = gt_w[i-1];
      assign lk = key_w[i-1];
      assign lt = tag_w[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign rv = 1'b0;
      assign rk = key_w[i];
      assign rt = tag_w[i];
    end else begin : g_inner
      assign rv = valid_w[i+1];
      assign rk = key_w[i+1];
      assign rt = tag_w[i+1];
    end

    srs_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .new_key_i     (new_key_i),
      .new_tag_i     (new_tag_i),
      .left_valid_i  (lv),
      .left_gt_i     (lg),
      .left_key_i    (lk),
      .left_tag_i    (lt),
      .right_valid_i (rv),
      .right_key_i   (rk),
      .right_tag_i   (rt),
      .valid_o       (valid_w[i]),
      .gt_o          (gt_w[i]),
      .key_o         (key_w[i]),
      .tag_o         (tag_w[i])
    );
  end

  assign head_key_o     = key_w[0];
  assign head_tag_o     = tag_w[0];
  assign second_valid_o = valid_w[1];
  assign full_o         = valid_w[MAX_RECORDS-1];

endmodule

[design/stable_record_sorter_top.sv]
// ----------------------------------------------------------------------------
// Stable record sorter
// Collects a set of records and returns them in ascending key order.
// ----------------------------------------------------------------------------
// Records enter on in_i, one transfer per cycle while the block collects.
// Each is placed at once into a chain of MAX_RECORDS cells: every cell
// compares its key with the new one and keeps, takes the new record or takes
// its left neighbour's, so the chain stays sorted and equal keys keep their
// arrival order. A record that arrives with the chain full is dropped and
// the set is marked as overflowed.
// The record with end_of_set starts the read-out. The first sorted record is
// on out_o in the cycle after that transfer, and the chain then shifts one
// record towards the head per output transfer.
// in_i is not ready during read-out.
// The last record carries final_record; all carry the overflow mark.
// When the receiver stalls, the head record stays on out_o unchanged.
// Reset empties the chain and clears the overflow mark; key and tag storage
// is not reset.
// ----------------------------------------------------------------------------
module stable_record_sorter_top #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srs_stream_if.sink   in_i,
  srs_stream_if.source out_o
);
  import srs_pkg::*;

  logic                       emit_q, emit_d;
  logic                       drop_q, drop_d;
  logic                       in_xfer, out_xfer;
  logic                       full, second_valid;
  cell_ctrl_t                 ctrl;
  logic signed [KEY_BITS-1:0] head_key;
  logic [TAG_BITS-1:0]        head_tag, new_tag;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign new_tag  = TAG_BITS'(in_i.data.payload_tag);

  // Insert when there is room, shift towards the head on each output transfer.
  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;

  srs_chain #(
    .MAX_RECORDS (MAX_RECORDS),
    .TAG_BITS    (TAG_BITS)
  ) u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .new_key_i      (in_i.data.sort_key),
    .new_tag_i      (new_tag),
    .head_key_o     (head_key),
    .head_tag_o     (head_tag),
    .second_valid_o (second_valid),
    .full_o         (full)
  );

  // Collect and read-out phases, and the overflow mark of the set.
  always_comb begin
    emit_d = emit_q;
    drop_d = drop_q;
    if (in_xfer) begin
      if (full) begin
        drop_d = 1'b1;
      end
      if (in_i.data.end_of_set) begin
        emit_d = 1'b1;
      end
    end
    if (out_xfer && !second_valid) begin
      emit_d = 1'b0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      emit_q <= emit_d;
      drop_q <= drop_d;
    end
  end

  assign in_i.ready              = !emit_q;
  assign out_o.valid             = emit_q;
  assign out_o.data.sorted_key   = head_key;
  assign out_o.data.sorted_tag   = TAG_OUT_BITS'(head_tag);
  assign out_o.data.final_record = !second_valid;
  assign out_o.data.overflowed   = drop_q;

endmodule
